// File: hw/rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types and constants of the bounded stack with peek by depth.
// ----------------------------------------------------------------------------
package stk_pkg;

   // width of the count, capacity and peek depth fields
   localparam int CNT_W    = 7;
   localparam int VAL_W    = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 4;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_TOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_BAD_DEPTH = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;      // request item accepted this cycle
      logic load_out;  // move pending result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_valid;
   } stat_type;

endpackage

// File: hw/rtl/lifo_stack_with_peek.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_peek
// Bounded stack of signed words with push, pop, peek by depth and read top.
// ----------------------------------------------------------------------------
// Every request item gives one response item with the word read, a status
// (ok, overflow, underflow, invalid peek depth) and the empty flag, full flag
// and entry count after the request. The idle state takes a request, updates
// the fill count and addresses the stack RAM; the read state, held by a
// stalled output, moves the registered RAM read into the output register.
// The next request is taken while a response waits. The capacity register
// (csr_data) may be written while the block is idle; 0 acts as 1, values
// above DEPTH act as DEPTH. The stack RAM needs no clearing after reset.
module lifo_stack_with_peek #(
   parameter int DEPTH     = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // push_value [31:0], peek_depth [38:32], zero [39]
   input  logic [stk_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op [1:0]
   input  logic [stk_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0], entry_count [38:32], zero [39]
   output logic [stk_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status [1:0], is_empty [2], is_full [3]
   output logic [stk_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [stk_pkg::CNT_W-1:0]        csr_data
);
   import stk_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic [VAL_W-1:0] read_value;
   logic [1:0]       status;
   logic             is_empty;
   logic             is_full;
   logic [CNT_W-1:0] entry_count;

   assign csr_ready = 1'b1;

   stk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   stk_dpath #(
      .DEPTH     (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .req_op          (req_tuser[1:0]),
      .req_push_value  (req_tdata[VAL_W-1:0]),
      .req_peek_depth  (req_tdata[VAL_W+CNT_W-1:VAL_W]),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_read_value  (read_value),
      .rsp_status      (status),
      .rsp_is_empty    (is_empty),
      .rsp_is_full     (is_full),
      .rsp_entry_count (entry_count)
   );

   assign rsp_tdata = {1'b0, entry_count, read_value};
   assign rsp_tuser = {is_full, is_empty, status};

endmodule

// File: hw/rtl/stk_ram.sv
// ----------------------------------------------------------------------------
// stk_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/stk_ctrl.sv
// ----------------------------------------------------------------------------
// stk_ctrl
// Request sequencer: accepts a request, then hands the RAM read result to
// the output register once that register is free.
// ----------------------------------------------------------------------------
module stk_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             rsp_tready,
   input  stk_pkg::stat_type stat,
   output stk_pkg::cmd_type  cmd
);
   import stk_pkg::*;

   state_type state_ff, state_in;
   logic      out_free;

   assign out_free = !stat.out_valid || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd.take     = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         S_READ: begin
            cmd.load_out = out_free;
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/stk_dpath.sv
// ----------------------------------------------------------------------------
// stk_dpath
// Stack datapath: fill count, capacity register, request decode, stack RAM
// and the result register.
// ----------------------------------------------------------------------------
module stk_dpath #(
   parameter int DEPTH     = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  stk_pkg::cmd_type            cmd,
   output stk_pkg::stat_type           stat,
   input  logic                        csr_valid,
   input  logic [stk_pkg::CNT_W-1:0]   csr_data,
   input  logic [1:0]                  req_op,
   input  logic [stk_pkg::VAL_W-1:0]   req_push_value,
   input  logic [stk_pkg::CNT_W-1:0]   req_peek_depth,
   input  logic                        rsp_tready,
   output logic                        rsp_valid,
   output logic [stk_pkg::VAL_W-1:0]   rsp_read_value,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full,
   output logic [stk_pkg::CNT_W-1:0]   rsp_entry_count
);
   import stk_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW = (AW > CNT_W) ? AW : CNT_W;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_ff;
   logic [CNT_W-1:0] cap_eff;

   // pending result, waiting on the RAM read
   status_type       pend_status_ff, pend_status_in;
   logic             pend_use_ff, pend_use_in;
   logic             pend_empty_ff;
   logic             pend_full_ff;
   logic [CNT_W-1:0] pend_count_ff;

   logic             out_valid_ff;
   logic [VAL_W-1:0] out_value_ff;
   logic [1:0]       out_status_ff;
   logic             out_empty_ff;
   logic             out_full_ff;
   logic [CNT_W-1:0] out_count_ff;

   logic                 ram_we, ram_re;
   logic [IW-1:0]        waddr_w, raddr_w;
   logic [VAL_W-1:0]     ram_wdata, ram_rdata;
   logic [VAL_W-1:0]     rd_ext;
   op_type               op;

   assign op = op_type'(req_op);

   // zero acts as one, anything above the built depth acts as the depth
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > DEPTH) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   always_comb begin
      count_in       = count_ff;
      pend_status_in = STAT_OK;
      pend_use_in    = 1'b0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      waddr_w        = IW'(count_ff);
      raddr_w        = IW'(count_ff - CNT_W'(1));
      unique case (op)
         OP_PUSH: begin
            if (count_ff >= cap_eff) begin
               pend_status_in = STAT_OVERFLOW;
            end else begin
               ram_we   = cmd.take;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               pend_status_in = STAT_UNDERFLOW;
            end else begin
               ram_re      = cmd.take;
               pend_use_in = 1'b1;
               count_in    = count_ff - CNT_W'(1);
            end
         end
         OP_PEEK: begin
            if (req_peek_depth == '0 || req_peek_depth > count_ff) begin
               pend_status_in = STAT_BAD_DEPTH;
            end else begin
               ram_re      = cmd.take;
               pend_use_in = 1'b1;
               raddr_w     = IW'(count_ff - req_peek_depth);
            end
         end
         OP_TOP: begin
            if (count_ff == '0) begin
               pend_status_in = STAT_UNDERFLOW;
            end else begin
               ram_re      = cmd.take;
               pend_use_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign ram_wdata = req_push_value;

   stk_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr_w[AW-1:0]),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (raddr_w[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CNT_W'(64);
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         if (cmd.take) begin
            count_ff <= count_in;
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pend_status_ff <= pend_status_in;
         pend_use_ff    <= pend_use_in;
         pend_empty_ff  <= (count_in == '0);
         pend_full_ff   <= (count_in >= cap_eff);
         pend_count_ff  <= count_in;
      end
   end

   // error and push results read as all ones of a stored word
   assign rd_ext = pend_use_ff ? ram_rdata : {VAL_W{1'b1}};

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_value_ff  <= rd_ext;
         out_status_ff <= pend_status_ff;
         out_empty_ff  <= pend_empty_ff;
         out_full_ff   <= pend_full_ff;
         out_count_ff  <= pend_count_ff;
      end
   end

   assign stat.out_valid   = out_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_read_value   = out_value_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_is_empty     = out_empty_ff;
   assign rsp_is_full      = out_full_ff;
   assign rsp_entry_count  = out_count_ff;

endmodule

// File: hw/rtl/stk_checker.sv
// ----------------------------------------------------------------------------
// stk_checker
// Port level checks of the stack, bound to the top level.
// ----------------------------------------------------------------------------
module stk_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [stk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [stk_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import stk_pkg::*;

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[2] == (rsp_tdata[38:32] == '0)))
      else $error("empty flag disagrees with count");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STAT_OVERFLOW |-> rsp_tuser[3])
      else $error("overflow reported while not full");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STAT_UNDERFLOW |-> rsp_tuser[2])
      else $error("underflow reported while not empty");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response item right after reset");

endmodule

bind lifo_stack_with_peek stk_checker u_stk_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
